// ===== rtl/hbe_pkg.sv =====
// shared types and constants of the binned histogram engine
package hbe_pkg;

  localparam int unsigned BIN_COUNT_DEF = 64;
  localparam logic [31:0] LOW_RESET     = 32'd1000;
  localparam logic [31:0] HIGH_RESET    = 32'd10000;

  typedef enum logic [1:0] {
    ACT_ADD   = 2'd0,
    ACT_READ  = 2'd1,
    ACT_CLEAR = 2'd2,
    ACT_NONE  = 2'd3
  } act_e;

  localparam logic [1:0] CLS_IN    = 2'd0;
  localparam logic [1:0] CLS_UNDER = 2'd1;
  localparam logic [1:0] CLS_OVER  = 2'd2;
  localparam logic [1:0] CLS_NONE  = 2'd3;

  localparam logic REG_RANGE_LOW  = 1'b0;
  localparam logic REG_RANGE_HIGH = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WIDTH,
    ST_WSCALE,
    ST_CLASS,
    ST_DIV,
    ST_RMW,
    ST_READ
  } state_e;

  typedef struct packed {
    logic        start;
    logic [31:0] num;
    logic [31:0] den;
    logic [5:0]  steps;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quo;
  } div_rsp_t;

endpackage

// ===== rtl/binned_histogram_engine.sv =====
// Binned histogram engine: counts unsigned samples into BIN_COUNT equal-width
// bins between range_low and range_high, plus underflow, overflow and total
// counters. One transaction is taken while busy is low; its result appears
// on the result ports for one cycle with done_o, and must be taken then. An
// add below or above range is classified and answered without the divider;
// an add in range runs the serial bin divider, which gives one quotient bit
// a cycle, or goes straight to the last bin if the quotient would not fit,
// then a read-modify-write of the bin memory. A read answers from the
// registered bin memory read, and a clear answers and then sweeps zeros
// through the bin memory one entry a cycle. After reset the same sweep runs.
// A write of either range register keeps busy high while the bin width
// (range_high - range_low) / BIN_COUNT is recomputed by a reciprocal multiply.
module binned_histogram_engine
  import hbe_pkg::*;
#(
  parameter int unsigned BIN_COUNT = BIN_COUNT_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // apb configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // command side
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  action_i,
  input  logic [31:0] sample_value_i,
  input  logic [5:0]  read_index_i,
  // result side
  output logic        done_o,
  output logic [1:0]  sample_class_o,
  output logic [5:0]  bin_index_o,
  output logic [31:0] bin_count_o,
  output logic [31:0] underflow_total_o,
  output logic [31:0] overflow_total_o,
  output logic [31:0] sample_total_o
);

  localparam int unsigned AW        = $clog2(BIN_COUNT);
  localparam logic [AW-1:0] LAST    = AW'(BIN_COUNT - 1);
  localparam logic [5:0] BIN_STEPS  = 6'(AW);
  localparam int unsigned WIDTH_DIV = (HIGH_RESET - LOW_RESET) / BIN_COUNT;
  localparam logic [31:0] WIDTH_RST = (WIDTH_DIV == 0) ? 32'd1 : 32'(WIDTH_DIV);
  // magic number for an exact 32-bit divide by BIN_COUNT
  localparam logic [63:0] REC_NUM   = ((64'd1 << AW) - 64'(BIN_COUNT)) << 32;
  localparam logic [31:0] REC_M     = 32'(REC_NUM / 64'(BIN_COUNT) + 64'd1);

  state_e      state_q, state_d;
  logic        dirty_q, dirty_d;
  logic [31:0] low_q, high_q;
  logic [31:0] width_q, width_d;
  logic [31:0] wdiff_q, wdiff_d;
  logic [31:0] whi_q, whi_d;
  logic [AW-1:0] clr_q, clr_d;
  logic [AW-1:0] bin_q, bin_d;
  logic [31:0] unf_q, unf_d;
  logic [31:0] ovf_q, ovf_d;
  logic [31:0] tot_q, tot_d;
  logic        done_q, done_d;
  logic [31:0] smp_q, smp_d;
  logic        oor_q, oor_d;
  logic [1:0]  cls_q, cls_d;
  logic [5:0]  idx_q, idx_d;
  logic [31:0] cnt_q, cnt_d;

  logic        cfg_wr;
  logic [31:0] diff;
  logic        sat;
  logic [AW-1:0] div_bin;
  logic [63:0] wprod;
  logic [31:0] wquo;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [31:0]   ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [31:0]   ram_rdata;

  div_req_t div_req;
  div_rsp_t div_rsp;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == REG_RANGE_HIGH) ? high_q : low_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q  <= LOW_RESET;
      high_q <= HIGH_RESET;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_RANGE_LOW:  low_q  <= pwdata;
        REG_RANGE_HIGH: high_q <= pwdata;
        default:        low_q  <= low_q;
      endcase
    end
  end

  assign diff    = smp_q - low_q;
  // quotient would not fit the bin divider: clamp straight to the last bin
  assign sat     = {32'd0, diff} >= ({32'd0, width_q} << AW);
  assign div_bin = (div_rsp.quo >= 32'(BIN_COUNT)) ? LAST : AW'(div_rsp.quo);

  // width = diff / BIN_COUNT as high product word plus a halved fixup
  assign wprod = {32'd0, REC_M} * {32'd0, wdiff_q};
  assign wquo  = (whi_q + ((wdiff_q - whi_q) >> 1)) >> (AW - 1);

  always_comb begin
    state_d   = state_q;
    dirty_d   = dirty_q | cfg_wr;
    width_d   = width_q;
    wdiff_d   = wdiff_q;
    whi_d     = whi_q;
    clr_d     = clr_q;
    bin_d     = bin_q;
    unf_d     = unf_q;
    ovf_d     = ovf_q;
    tot_d     = tot_q;
    done_d    = 1'b0;
    smp_d     = smp_q;
    oor_d     = oor_q;
    cls_d     = cls_q;
    idx_d     = idx_q;
    cnt_d     = cnt_q;
    ram_we    = 1'b0;
    ram_waddr = clr_q;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = bin_q;
    div_req   = '0;

    case (state_q)
      ST_CLEAR: begin
        ram_we = 1'b1;
        clr_d  = clr_q + AW'(1);
        if (clr_q == LAST) begin
          clr_d   = '0;
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (dirty_q) begin
          wdiff_d = high_q - low_q;
          dirty_d = cfg_wr;
          state_d = ST_WIDTH;
        end else if (start) begin
          case (action_i)
            ACT_ADD: begin
              smp_d   = sample_value_i;
              state_d = ST_CLASS;
            end
            ACT_READ: begin
              ram_re    = 1'b1;
              ram_raddr = AW'(read_index_i);
              idx_d     = read_index_i;
              oor_d     = {26'd0, read_index_i} >= 32'(BIN_COUNT);
              state_d   = ST_READ;
            end
            ACT_CLEAR: begin
              unf_d   = '0;
              ovf_d   = '0;
              tot_d   = '0;
              done_d  = 1'b1;
              cls_d   = CLS_NONE;
              idx_d   = '0;
              cnt_d   = '0;
              state_d = ST_CLEAR;
            end
            default: begin
              done_d = 1'b1;
              cls_d  = CLS_NONE;
              idx_d  = '0;
              cnt_d  = '0;
            end
          endcase
        end
      end
      ST_WIDTH: begin
        whi_d   = wprod[63:32];
        state_d = ST_WSCALE;
      end
      ST_WSCALE: begin
        width_d = (wquo == 32'd0) ? 32'd1 : wquo;
        state_d = ST_IDLE;
      end
      ST_CLASS: begin
        if (smp_q < low_q) begin
          unf_d   = unf_q + 32'd1;
          tot_d   = tot_q + 32'd1;
          done_d  = 1'b1;
          cls_d   = CLS_UNDER;
          idx_d   = '0;
          cnt_d   = '0;
          state_d = ST_IDLE;
        end else if (smp_q >= high_q) begin
          ovf_d   = ovf_q + 32'd1;
          tot_d   = tot_q + 32'd1;
          done_d  = 1'b1;
          cls_d   = CLS_OVER;
          idx_d   = '0;
          cnt_d   = '0;
          state_d = ST_IDLE;
        end else if (sat) begin
          bin_d     = LAST;
          ram_re    = 1'b1;
          ram_raddr = LAST;
          state_d   = ST_RMW;
        end else begin
          div_req.start = 1'b1;
          div_req.num   = diff;
          div_req.den   = width_q;
          div_req.steps = BIN_STEPS;
          state_d       = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          bin_d     = div_bin;
          ram_re    = 1'b1;
          ram_raddr = div_bin;
          state_d   = ST_RMW;
        end
      end
      ST_RMW: begin
        ram_we    = 1'b1;
        ram_waddr = bin_q;
        ram_wdata = ram_rdata + 32'd1;
        tot_d     = tot_q + 32'd1;
        done_d    = 1'b1;
        cls_d     = CLS_IN;
        idx_d     = 6'(bin_q);
        cnt_d     = ram_rdata + 32'd1;
        state_d   = ST_IDLE;
      end
      ST_READ: begin
        done_d  = 1'b1;
        cls_d   = CLS_NONE;
        cnt_d   = oor_q ? 32'd0 : ram_rdata;
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      dirty_q <= 1'b0;
      width_q <= WIDTH_RST;
      clr_q   <= '0;
      unf_q   <= '0;
      ovf_q   <= '0;
      tot_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      dirty_q <= dirty_d;
      width_q <= width_d;
      clr_q   <= clr_d;
      unf_q   <= unf_d;
      ovf_q   <= ovf_d;
      tot_q   <= tot_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wdiff_q <= wdiff_d;
    whi_q   <= whi_d;
    bin_q   <= bin_d;
    smp_q   <= smp_d;
    oor_q   <= oor_d;
    cls_q   <= cls_d;
    idx_q   <= idx_d;
    cnt_q   <= cnt_d;
  end

  hbe_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  hbe_bin_ram #(
    .DEPTH (BIN_COUNT)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign busy              = (state_q != ST_IDLE) || dirty_q;
  assign done_o            = done_q;
  assign sample_class_o    = cls_q;
  assign bin_index_o       = idx_q;
  assign bin_count_o       = cnt_q;
  assign underflow_total_o = unf_q;
  assign overflow_total_o  = ovf_q;
  assign sample_total_o    = tot_q;

  // a range write always leaves a width recompute pending
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_wr |=> dirty_q)
    else $error("range write did not schedule width update");

  // counters only move on a result transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tot_q != $past(tot_q)) || (unf_q != $past(unf_q)) || (ovf_q != $past(ovf_q))
    |-> done_q)
    else $error("counter changed without a result");

  // the bin update follows classification or the bin divider
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RMW) |-> ($past(state_q) == ST_CLASS) || ($past(state_q) == ST_DIV))
    else $error("bin update entered from a wrong state");

  // the bin divider finishes only while it is awaited
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == ST_DIV))
    else $error("divider result not awaited");

  // no new transaction is taken while the result of an add is pending
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLASS) || (state_q == ST_DIV) || (state_q == ST_RMW) |-> busy)
    else $error("ready while an add is in progress");

endmodule

// ===== rtl/hbe_div.sv =====
// serial restoring divider, one quotient bit per cycle, bounded quotient length
module hbe_div
  import hbe_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic [5:0]  cnt_q, cnt_d;
  logic        done_q;
  logic [31:0] rem_q, rem_d;
  logic [63:0] den_q, den_d;
  logic [31:0] quo_q, quo_d;
  logic        fits;

  // caller guarantees num < den << steps, so the quotient has steps bits
  assign fits = {32'd0, rem_q} >= den_q;

  always_comb begin
    cnt_d = cnt_q;
    rem_d = rem_q;
    den_d = den_q;
    quo_d = quo_q;
    if (req_i.start) begin
      cnt_d = req_i.steps;
      rem_d = req_i.num;
      den_d = {32'd0, req_i.den} << (req_i.steps - 6'd1);
      quo_d = '0;
    end else if (cnt_q != 6'd0) begin
      cnt_d = cnt_q - 6'd1;
      den_d = den_q >> 1;
      if (fits) begin
        rem_d = rem_q - den_q[31:0];
        quo_d = {quo_q[30:0], 1'b1};
      end else begin
        quo_d = {quo_q[30:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= !req_i.start && (cnt_q == 6'd1);
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    quo_q <= quo_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;

endmodule

// ===== rtl/hbe_bin_ram.sv =====
// bin counter memory, one write and one registered read port
module hbe_bin_ram
  import hbe_pkg::*;
#(
  parameter int unsigned DEPTH = BIN_COUNT_DEF,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [31:0]   wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [31:0]   rdata_o
);

  logic [31:0] mem_q [DEPTH];
  logic [31:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== tb/tb_binned_histogram_engine.sv =====
// self-checking testbench of the binned histogram engine with its own histogram predictor
module tb_binned_histogram_engine;
  timeunit 1ns;
  timeprecision 1ps;
  import hbe_pkg::*;

  localparam int unsigned NBINS = BIN_COUNT_DEF;
  localparam logic [31:0] NBINS_W = 32'(BIN_COUNT_DEF);
  localparam int unsigned IDLE_LIMIT = 4000;
  localparam int unsigned DRAIN_CYCLES = 80;
  localparam int unsigned ITEMS_PER_PHASE = 55;
  localparam int unsigned NUM_PHASES = 9;

  typedef struct packed {
    logic [1:0]  cls;
    logic [5:0]  idx;
    logic [31:0] cnt;
    logic [31:0] und;
    logic [31:0] ovr;
    logic [31:0] tot;
  } hist_res_t;

  typedef struct packed {
    act_e        act;
    logic [31:0] smp;
    logic [5:0]  ridx;
    logic        typed;
    hist_res_t   res;
  } stim_row_t;

  // reset bounds 1000..10000 give a bin width of 140
  localparam stim_row_t DIRECTED [17] = '{
    '{ACT_READ,  32'd0,          6'd0,  1'b1, '{CLS_NONE,  6'd0,  32'd0, 32'd0, 32'd0, 32'd0}},
    '{ACT_READ,  32'd0,          6'd63, 1'b1, '{CLS_NONE,  6'd63, 32'd0, 32'd0, 32'd0, 32'd0}},
    '{ACT_ADD,   32'd0,          6'd0,  1'b1, '{CLS_UNDER, 6'd0,  32'd0, 32'd1, 32'd0, 32'd1}},
    '{ACT_ADD,   32'hFFFF_FFFF,  6'd63, 1'b1, '{CLS_OVER,  6'd0,  32'd0, 32'd1, 32'd1, 32'd2}},
    '{ACT_ADD,   32'd999,        6'd0,  1'b1, '{CLS_UNDER, 6'd0,  32'd0, 32'd2, 32'd1, 32'd3}},
    '{ACT_ADD,   32'd10000,      6'd0,  1'b1, '{CLS_OVER,  6'd0,  32'd0, 32'd2, 32'd2, 32'd4}},
    '{ACT_ADD,   32'd1000,       6'd0,  1'b1, '{CLS_IN,    6'd0,  32'd1, 32'd2, 32'd2, 32'd5}},
    '{ACT_ADD,   32'd9999,       6'd0,  1'b1, '{CLS_IN,    6'd63, 32'd1, 32'd2, 32'd2, 32'd6}},
    '{ACT_ADD,   32'd1140,       6'd0,  1'b1, '{CLS_IN,    6'd1,  32'd1, 32'd2, 32'd2, 32'd7}},
    '{ACT_ADD,   32'd1139,       6'd0,  1'b0, '0},
    '{ACT_ADD,   32'd9998,       6'd0,  1'b0, '0},
    '{ACT_READ,  32'hFFFF_FFFF,  6'd63, 1'b0, '0},
    '{ACT_NONE,  32'hFFFF_FFFF,  6'd63, 1'b1, '{CLS_NONE,  6'd0,  32'd0, 32'd2, 32'd2, 32'd9}},
    '{ACT_ADD,   32'd5000,       6'd0,  1'b0, '0},
    '{ACT_CLEAR, 32'hFFFF_FFFF,  6'd63, 1'b1, '{CLS_NONE,  6'd0,  32'd0, 32'd0, 32'd0, 32'd0}},
    '{ACT_READ,  32'd0,          6'd1,  1'b1, '{CLS_NONE,  6'd1,  32'd0, 32'd0, 32'd0, 32'd0}},
    '{ACT_ADD,   32'd1001,       6'd0,  1'b0, '0}
  };

  // range settings of the random phases; entry 6 is drawn at run time
  logic [31:0] phase_low  [NUM_PHASES] = '{32'd0, 32'd0, 32'd100, 32'd5000, 32'h8000_0000,
                                           32'hFFFF_FFFF, 32'd0, 32'd0, 32'd1000};
  logic [31:0] phase_high [NUM_PHASES] = '{32'd64, 32'hFFFF_FFFF, 32'd110, 32'd1000,
                                           32'h8000_1000, 32'hFFFF_FFFF, 32'd0, 32'd0,
                                           32'd10000};

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        start;
  logic        busy;
  logic [1:0]  action_i;
  logic [31:0] sample_value_i;
  logic [5:0]  read_index_i;
  logic        done_o;
  logic [1:0]  sample_class_o;
  logic [5:0]  bin_index_o;
  logic [31:0] bin_count_o;
  logic [31:0] underflow_total_o;
  logic [31:0] overflow_total_o;
  logic [31:0] sample_total_o;

  // predictor state
  logic [31:0] cfg_low;
  logic [31:0] cfg_high;
  logic [31:0] bin_tally [NBINS];
  logic [31:0] under_tally;
  logic [31:0] over_tally;
  logic [31:0] sample_tally;

  hist_res_t   expected_results_q [$];
  int unsigned n_errors;
  int unsigned n_results;
  int unsigned n_cfg_writes;
  int unsigned act_seen [4];
  int unsigned idle_cycles;

  binned_histogram_engine dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .start             (start),
    .busy              (busy),
    .action_i          (action_i),
    .sample_value_i    (sample_value_i),
    .read_index_i      (read_index_i),
    .done_o            (done_o),
    .sample_class_o    (sample_class_o),
    .bin_index_o       (bin_index_o),
    .bin_count_o       (bin_count_o),
    .underflow_total_o (underflow_total_o),
    .overflow_total_o  (overflow_total_o),
    .sample_total_o    (sample_total_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic report_mismatch(string msg);
    $display("MISMATCH at %0t ns: %s", $time, msg);
    n_errors++;
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s = %h, predicted %h", n_results, name, got, want));
  endtask

  function automatic void clear_histogram();
    foreach (bin_tally[i]) bin_tally[i] = '0;
    under_tally  = '0;
    over_tally   = '0;
    sample_tally = '0;
  endfunction

  function automatic hist_res_t predict_histogram(act_e act, logic [31:0] smp,
                                                  logic [5:0] ridx);
    hist_res_t   r;
    logic [31:0] width;
    logic [31:0] bin;
    r = '{CLS_NONE, 6'd0, 32'd0, 32'd0, 32'd0, 32'd0};
    case (act)
      ACT_ADD: begin
        sample_tally++;
        if (smp < cfg_low) begin
          under_tally++;
          r.cls = CLS_UNDER;
        end else if (smp >= cfg_high) begin
          over_tally++;
          r.cls = CLS_OVER;
        end else begin
          width = (cfg_high - cfg_low) / NBINS_W;
          if (width == 32'd0) width = 32'd1;
          bin = (smp - cfg_low) / width;
          if (bin >= NBINS_W) bin = NBINS_W - 32'd1;
          bin_tally[bin]++;
          r.cls = CLS_IN;
          r.idx = bin[5:0];
          r.cnt = bin_tally[bin];
        end
      end
      ACT_READ: begin
        r.idx = ridx;
        if (32'(ridx) < NBINS_W) r.cnt = bin_tally[ridx];
      end
      ACT_CLEAR: clear_histogram();
      default: ;
    endcase
    r.und = under_tally;
    r.ovr = over_tally;
    r.tot = sample_tally;
    return r;
  endfunction

  task automatic send_item(act_e act, logic [31:0] smp, logic [5:0] ridx, logic typed,
                           hist_res_t typed_res);
    hist_res_t pred;
    start          <= 1'b1;
    action_i       <= act;
    sample_value_i <= smp;
    read_index_i   <= ridx;
    do @(posedge clk_i); while (busy !== 1'b0);
    pred = predict_histogram(act, smp, ridx);
    expected_results_q.push_back(typed ? typed_res : pred);
    act_seen[int'(act)]++;
  endtask

  task automatic idle_sender(int unsigned cycles);
    if (cycles != 0) begin
      start <= 1'b0;
      repeat (cycles) @(posedge clk_i);
    end
  endtask

  // always waits for a clock edge before returning, so start is never dropped and raised in one step
  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk_i); while (expected_results_q.size() != 0 || busy !== 1'b0);
  endtask

  task automatic set_range_reg(logic sel, logic [31:0] val);
    logic [31:0] rd;
    while (busy !== 1'b0) @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    if (sel == REG_RANGE_LOW) cfg_low = val;
    else cfg_high = val;
    // read back through a second transaction
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    rd = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (rd !== val)
      report_mismatch($sformatf("range register %0d read back %h, written %h", sel, rd, val));
    n_cfg_writes++;
  endtask

  function automatic int unsigned pick_gap(bit steady);
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (steady || sel < 35) return 0;
    if (sel < 94) return $urandom_range(1, 3);
    return $urandom_range(15, 60);
  endfunction

  function automatic logic [31:0] pick_sample();
    int unsigned sel;
    logic [31:0] span;
    sel  = $urandom_range(0, 99);
    span = cfg_high - cfg_low;
    if (sel < 55 && cfg_high > cfg_low) return cfg_low + $urandom_range(0, span - 32'd1);
    if (sel < 70) begin
      case ($urandom_range(0, 3))
        0: return cfg_low - 32'd1;
        1: return cfg_low;
        2: return cfg_high - 32'd1;
        default: return cfg_high;
      endcase
    end
    if (sel < 78) return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd0;
    return $urandom;
  endfunction

  function automatic act_e pick_action();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 68) return ACT_ADD;
    if (sel < 86) return ACT_READ;
    if (sel < 89) return ACT_CLEAR;
    return ACT_NONE;
  endfunction

  // results cannot be held off, so every strobe is checked at the edge that ends it
  always @(posedge clk_i) begin
    hist_res_t want;
    if (rst_ni && done_o !== 1'b0) begin
      if (expected_results_q.size() == 0) begin
        report_mismatch("result strobe with no transaction outstanding");
      end else begin
        want = expected_results_q.pop_front();
        check_field("sample_class", 32'(sample_class_o), 32'(want.cls));
        check_field("bin_index", 32'(bin_index_o), 32'(want.idx));
        check_field("bin_count", bin_count_o, want.cnt);
        check_field("underflow_total", underflow_total_o, want.und);
        check_field("overflow_total", overflow_total_o, want.ovr);
        check_field("sample_total", sample_total_o, want.tot);
      end
      n_results++;
    end
  end

  always @(posedge clk_i) begin
    if ((start && !busy) || done_o || (psel && penable)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no transaction for %0d cycles, %0d results outstanding",
                 IDLE_LIMIT, expected_results_q.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    act_e act;
    logic [31:0] smp;
    clk_i          = 1'b0;
    rst_ni         <= 1'b0;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    start          <= 1'b0;
    action_i       <= ACT_NONE;
    sample_value_i <= '0;
    read_index_i   <= '0;
    n_errors       = 0;
    n_results      = 0;
    n_cfg_writes   = 0;
    idle_cycles    = 0;
    foreach (act_seen[i]) act_seen[i] = 0;
    cfg_low  = LOW_RESET;
    cfg_high = HIGH_RESET;
    clear_histogram();
    phase_low[6]  = $urandom;
    phase_high[6] = $urandom;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int k = 0; k < $size(DIRECTED); k++) begin
      send_item(DIRECTED[k].act, DIRECTED[k].smp, DIRECTED[k].ridx, DIRECTED[k].typed,
                DIRECTED[k].res);
      idle_sender(pick_gap(1'b0));
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_drained();
      set_range_reg(REG_RANGE_LOW, phase_low[p]);
      set_range_reg(REG_RANGE_HIGH, phase_high[p]);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        act = pick_action();
        smp = (act == ACT_ADD) ? pick_sample() : 32'($urandom);
        send_item(act, smp, 6'($urandom), 1'b0, '0);
        if (i == 40) wait_drained();
        else idle_sender(pick_gap(i >= 20 && i < 35));
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (expected_results_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_results_q.size()));

    $display("covered %0d add, %0d read, %0d clear and %0d unused-action transactions",
             act_seen[ACT_ADD], act_seen[ACT_READ], act_seen[ACT_CLEAR], act_seen[ACT_NONE]);
    $display("over %0d range settings (%0d register writes), %0d results checked",
             NUM_PHASES + 1, n_cfg_writes, n_results);
    if (n_errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/hbe_pkg.sv
rtl/hbe_div.sv
rtl/hbe_bin_ram.sv
rtl/binned_histogram_engine.sv
tb/tb_binned_histogram_engine.sv
